[src/dscm_pkg.sv]
// ----------------------------------------------------------------------------
// dscm_pkg - shared types and constants for the column-minimum scan block
// Transfer structs, request and register codes, conversion constants.
// ----------------------------------------------------------------------------
package dscm_pkg;

	localparam int unsigned DSCM_MAX_COLUMNS   = 1024;
	localparam int unsigned DSCM_FRACTION_BITS = 16;

	localparam logic [1:0] REQ_PIXEL = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] CFG_DEPTH_MODE  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd1;
	localparam logic [1:0] CFG_RANGE_MIN   = 2'd2;
	localparam logic [1:0] CFG_RANGE_MAX   = 2'd3;

	localparam logic [32:0] DSCM_DEPTH_INF = 33'h1_0000_0000;
	localparam logic [15:0] DSCM_MM_ZERO   = 16'hFFFF;
	localparam logic [26:0] DSCM_MM_ROUND  = 27'd500;
	// ceil(2^36 / 1000): exact floor(x / 1000) for x < 2^26
	localparam logic [26:0] DSCM_RECIP_MUL = 27'd68719477;
	localparam int unsigned DSCM_RECIP_SHIFT = 36;
	localparam int unsigned DSCM_TABLE_FRAC  = 16;

	localparam logic [31:0] DSCM_RST_WIDTH = 32'd640;
	localparam logic [31:0] DSCM_RST_RMAX  = 32'd655360;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [9:0]  column;
		logic        first_row;
		logic [31:0] depth_raw;
		logic        depth_invalid;
		logic [19:0] inverse_cosine;
	} dscm_req_t;

	typedef struct packed {
		logic [9:0]  scan_index;
		logic [31:0] range_value;
		logic        range_is_infinite;
	} dscm_rsp_t;

	typedef struct packed {
		logic        depth_is_fixed_metres;
		logic [10:0] image_width;
		logic [31:0] range_min_metres;
		logic [31:0] range_max_metres;
	} dscm_cfg_t;

	// item after depth conversion; depth 2^32 is infinity
	typedef struct packed {
		logic [1:0]  req_type;
		logic [9:0]  column;
		logic        first_row;
		logic [32:0] depth;
		logic [19:0] inverse_cosine;
	} dscm_item_t;

endpackage

[src/dscm_ram.sv]
// ----------------------------------------------------------------------------
// dscm_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module dscm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/dscm_depth_conv.sv]
// ----------------------------------------------------------------------------
// dscm_depth_conv - depth conversion pipeline
// Millimetres to fixed metres by reciprocal multiply, or metre depth with
// invalid mapping to infinity. Three stages.
// ----------------------------------------------------------------------------
module dscm_depth_conv #(
	parameter int unsigned FRACTION_BITS = dscm_pkg::DSCM_FRACTION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 take,
	input  dscm_pkg::dscm_req_t  req,
	input  logic                 depth_is_fixed_metres,
	output logic                 item_valid,
	output dscm_pkg::dscm_item_t item
);
	import dscm_pkg::*;

	// 2^F = 1000 * ConvQ + ConvR
	localparam int unsigned ConvQ = (1 << FRACTION_BITS) / 1000;
	localparam int unsigned ConvR = (1 << FRACTION_BITS) % 1000;

	logic [15:0] mm;
	logic [31:0] whole_s1, whole_s2;
	logic [26:0] rem_s1;
	logic [32:0] metres_s1, metres_s2;
	logic [53:0] recip_prod;
	logic [16:0] quot_s2;
	logic        valid_s1, valid_s2;
	dscm_item_t  hdr_s1, hdr_s2;

	assign mm = (req.depth_raw[15:0] == 16'd0) ? DSCM_MM_ZERO : req.depth_raw[15:0];
	assign recip_prod = {27'd0, rem_s1} * {27'd0, DSCM_RECIP_MUL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			item_valid <= 1'b0;
		end else if (en) begin
			valid_s1   <= take;
			valid_s2   <= valid_s1;
			item_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s1.req_type       <= req.req_type;
			hdr_s1.column         <= req.column;
			hdr_s1.first_row      <= req.first_row;
			hdr_s1.depth          <= '0;
			hdr_s1.inverse_cosine <= req.inverse_cosine;
			whole_s1  <= 32'(mm) * 32'(ConvQ);
			rem_s1    <= 27'(mm) * 27'(ConvR) + DSCM_MM_ROUND;
			metres_s1 <= (req.depth_invalid || req.depth_raw == 32'd0) ?
				DSCM_DEPTH_INF : {1'b0, req.depth_raw};

			hdr_s2    <= hdr_s1;
			whole_s2  <= whole_s1;
			quot_s2   <= recip_prod[DSCM_RECIP_SHIFT+16:DSCM_RECIP_SHIFT];
			metres_s2 <= metres_s1;

			item.req_type       <= hdr_s2.req_type;
			item.column         <= hdr_s2.column;
			item.first_row      <= hdr_s2.first_row;
			item.inverse_cosine <= hdr_s2.inverse_cosine;
			item.depth          <= depth_is_fixed_metres ? metres_s2 :
				{1'b0, whole_s2 + 32'(quot_s2)};
		end
	end

endmodule

[src/dscm_range_out.sv]
// ----------------------------------------------------------------------------
// dscm_range_out - range scaling and output register
// Column minimum times 1/cos, rounding, limit checks, mirrored index.
// ----------------------------------------------------------------------------
module dscm_range_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                pick,
	input  logic [9:0]          column,
	input  logic                in_store,
	input  logic [32:0]         min_depth,
	input  logic [19:0]         inv_cos,
	input  dscm_pkg::dscm_cfg_t cfg,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output dscm_pkg::dscm_rsp_t rsp,
	output logic                hold
);
	import dscm_pkg::*;

	logic        valid_s5;
	logic [51:0] prod_s5;
	logic        inf_s5;
	logic [9:0]  column_s5;
	logic [52:0] rounded;
	logic [36:0] range_full;
	logic        out_inf;
	logic [10:0] mirror;

	assign hold = valid_s5 && rsp_valid && rsp_stall;

	assign rounded    = {1'b0, prod_s5} + 53'(1 << (DSCM_TABLE_FRAC - 1));
	assign range_full = rounded[DSCM_TABLE_FRAC+36:DSCM_TABLE_FRAC];
	assign out_inf    = inf_s5 || (range_full[36:32] != 5'd0)
		|| (range_full[31:0] < cfg.range_min_metres)
		|| (range_full[31:0] > cfg.range_max_metres);
	assign mirror     = cfg.image_width - 11'd1 - {1'b0, column_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (en) begin
				valid_s5 <= pick;
			end
			if (en && valid_s5) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5   <= {20'd0, min_depth[31:0]} * {32'd0, inv_cos};
			inf_s5    <= !in_store || min_depth[32];
			column_s5 <= column;
		end
		if (en && valid_s5) begin
			rsp.scan_index        <= mirror[9:0];
			rsp.range_value       <= out_inf ? 32'd0 : range_full[31:0];
			rsp.range_is_infinite <= out_inf;
		end
	end

endmodule

[src/depth_to_scan_column_min_core.sv]
// ----------------------------------------------------------------------------
// depth_to_scan_column_min_core - column-minimum depth image to laser scan
// Throughput: one transfer per cycle while req_stall is low; the column store is a forwarded RMW.
// A read result passes the conversion stages, the store stage, the scaling stage and the output register.
// req_stall rises only while a result waits at the output under rsp_stall.
// Reset clears control and configuration; data registers and both stores are undefined until written.
// ----------------------------------------------------------------------------
module depth_to_scan_column_min_core #(
	parameter int unsigned MAX_COLUMNS   = dscm_pkg::DSCM_MAX_COLUMNS,
	parameter int unsigned FRACTION_BITS = dscm_pkg::DSCM_FRACTION_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  dscm_pkg::dscm_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dscm_pkg::dscm_rsp_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import dscm_pkg::*;

	localparam int unsigned AddrW = $clog2(MAX_COLUMNS);

	dscm_cfg_t        cfg_q;
	logic             en, hold, take;
	logic             valid_s3, valid_s4;
	dscm_item_t       item_s3, item_s4;
	logic [31:0]      col_ext_s3;
	logic             in_store_s3, in_store_s4;
	logic [AddrW-1:0] addr_s3, addr_s4;
	logic [32:0]      min_rdata, min_cur;
	logic [19:0]      tbl_rdata, tbl_cur;
	logic             min_we, tbl_we;
	logic             fwd_min_valid_q, fwd_tbl_valid_q;
	logic [AddrW-1:0] fwd_min_addr_q, fwd_tbl_addr_q;
	logic [32:0]      fwd_min_data_q;
	logic [19:0]      fwd_tbl_data_q;

	assign en        = !hold;
	assign req_stall = hold;
	assign take      = req_valid && en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_is_fixed_metres <= 1'b0;
			cfg_q.image_width           <= DSCM_RST_WIDTH[10:0];
			cfg_q.range_min_metres      <= 32'd0;
			cfg_q.range_max_metres      <= DSCM_RST_RMAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEPTH_MODE:  cfg_q.depth_is_fixed_metres <= cfg_data[0];
				CFG_IMAGE_WIDTH: cfg_q.image_width           <= cfg_data[10:0];
				CFG_RANGE_MIN:   cfg_q.range_min_metres      <= cfg_data;
				CFG_RANGE_MAX:   cfg_q.range_max_metres      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dscm_depth_conv #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_conv (
		.clk                  (clk),
		.arst_n               (arst_n),
		.en                   (en),
		.take                 (take),
		.req                  (req),
		.depth_is_fixed_metres(cfg_q.depth_is_fixed_metres),
		.item_valid           (valid_s3),
		.item                 (item_s3)
	);

	assign col_ext_s3  = 32'(item_s3.column);
	assign in_store_s3 = col_ext_s3 < MAX_COLUMNS;
	assign addr_s3     = col_ext_s3[AddrW-1:0];

	dscm_ram #(
		.WIDTH(33),
		.DEPTH(MAX_COLUMNS)
	) u_min_ram (
		.clk  (clk),
		.we   (min_we),
		.waddr(addr_s4),
		.wdata(item_s4.depth),
		.re   (en),
		.raddr(addr_s3),
		.rdata(min_rdata)
	);

	dscm_ram #(
		.WIDTH(20),
		.DEPTH(MAX_COLUMNS)
	) u_tbl_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(addr_s4),
		.wdata(item_s4.inverse_cosine),
		.re   (en),
		.raddr(addr_s3),
		.rdata(tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4        <= 1'b0;
			fwd_min_valid_q <= 1'b0;
			fwd_tbl_valid_q <= 1'b0;
		end else if (en) begin
			valid_s4        <= valid_s3;
			fwd_min_valid_q <= min_we;
			fwd_tbl_valid_q <= tbl_we;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4        <= item_s3;
			in_store_s4    <= in_store_s3;
			addr_s4        <= addr_s3;
			fwd_min_addr_q <= addr_s4;
			fwd_min_data_q <= item_s4.depth;
			fwd_tbl_addr_q <= addr_s4;
			fwd_tbl_data_q <= item_s4.inverse_cosine;
		end
	end

	// write of the previous stage occupant lands on the same edge as this read
	assign min_cur = (fwd_min_valid_q && fwd_min_addr_q == addr_s4) ?
		fwd_min_data_q : min_rdata;
	assign tbl_cur = (fwd_tbl_valid_q && fwd_tbl_addr_q == addr_s4) ?
		fwd_tbl_data_q : tbl_rdata;

	assign min_we = en && valid_s4 && in_store_s4 && item_s4.req_type == REQ_PIXEL
		&& (item_s4.first_row || item_s4.depth < min_cur);
	assign tbl_we = en && valid_s4 && in_store_s4 && item_s4.req_type == REQ_LOAD;

	dscm_range_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.pick     (valid_s4 && item_s4.req_type == REQ_READ),
		.column   (item_s4.column),
		.in_store (in_store_s4),
		.min_depth(min_cur),
		.inv_cos  (tbl_cur),
		.cfg      (cfg_q),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.hold     (hold)
	);

endmodule

[src/dscm_checker.sv]
// ----------------------------------------------------------------------------
// dscm_checker - port-level checks for the column-minimum scan block
// Output hold, infinite encoding, stall cause, configuration acceptance, reset state.
// ----------------------------------------------------------------------------
module dscm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input dscm_pkg::dscm_rsp_t rsp,
	input logic                cfg_valid,
	input logic                cfg_ready
);
	import dscm_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.range_is_infinite |-> rsp.range_value == 32'd0)
		else $error("infinite range with non-zero value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without a blocked result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transfer refused");

	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !rsp_valid && !(req_valid && req_stall))
		else $error("activity straight out of reset");

endmodule

bind depth_to_scan_column_min_core dscm_checker u_dscm_checker (.*);
